@@ src/sha256_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned HashWords  = 8;

    typedef struct packed {
        logic [31:0] msg_word;
        logic        first_block;
        logic        last_block;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } out_t;

    // hash memory access for one cycle
    typedef struct packed {
        logic        init_all;
        logic [2:0]  rd_addr;
        logic        wr_en;
        logic [2:0]  wr_addr;
        logic [31:0] wr_data;
    } hmem_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOAD  = 4'b0010,
        S_ROUND = 4'b0100,
        S_ADD   = 4'b1000
    } state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ src/sha256_hmem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha256_hmem (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sha256_pkg::hmem_ctrl_t  ctrl,
    output logic [31:0]                  rd_data
);
    import sha256_pkg::*;

    logic [31:0] mem [HashWords];
    logic [HashWords-1:0] init_reg;
    logic [HashWords-1:0] init_next;
    logic [31:0] rdata_reg;
    logic [2:0]  raddr_reg;
    logic        rinit_reg;

    // an entry flagged init reads as the standard initial value
    always_comb
    begin
        init_next = init_reg;
        if (ctrl.wr_en)
        begin
            init_next[ctrl.wr_addr] = 1'b0;
        end
        if (ctrl.init_all)
        begin
            init_next = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= '1;
            rinit_reg <= 1'b1;
        end
        else
        begin
            init_reg  <= init_next;
            rinit_reg <= init_reg[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        rdata_reg <= mem[ctrl.rd_addr];
        raddr_reg <= ctrl.rd_addr;
    end

    assign rd_data = rinit_reg ? init_hash(raddr_reg) : rdata_reg;

endmodule

`default_nettype wire

@@ src/sha256_sched.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sha256_sched (
    input  wire logic        clk,
    input  wire logic        load,
    input  wire logic        step,
    input  wire logic [31:0] word_in,
    output logic [31:0]      w_cur
);
    import sha256_pkg::*;

    // window holds W[t] .. W[t+15], oldest at index 0
    logic [31:0] win_reg [BlockWords];
    logic [31:0] sg0;
    logic [31:0] sg1;
    logic [31:0] w_new;
    logic [31:0] shift_in;

    always_comb
    begin
        sg0      = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        sg1      = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new    = sg1 + win_reg[9] + sg0 + win_reg[0];
        shift_in = load ? word_in : w_new;
    end

    always_ff @(posedge clk)
    begin
        if (load || step)
        begin
            for (int i = 0; i < BlockWords - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BlockWords-1] <= shift_in;
        end
    end

    assign w_cur = win_reg[0];

endmodule

`default_nettype wire

@@ src/sha256_block_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                        | transaction
// ----------+------------------------------+----------------------------------
// message   | start, busy, msg (in_t)      | start high while busy low
// digest    | strobe, digest (out_t)       | strobe high, one cycle per word
//
// each block takes 16 message transactions, one per cycle at most
// after the 16th word the core is busy: it loads a..h from the one-read,
// one-write hash memory, runs 64 rounds at one per cycle, then adds back
// digest words leave one per cycle, registered from the add pass of a last block
// the receiver cannot stall; reset restores the initial hash values

module sha256_block_hash (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sha256_pkg::in_t   msg,
    output logic                   strobe,
    output sha256_pkg::out_t       digest
);
    import sha256_pkg::*;

    state_t      state_reg, state_next;
    logic [3:0]  word_cnt_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic [5:0]  round_reg, round_next;
    logic        last_reg;
    logic [31:0] v_reg [HashWords];
    logic        strobe_reg;
    out_t        digest_reg;

    logic        accept;
    hmem_ctrl_t  hctrl;
    logic [31:0] hrd;
    logic [31:0] sum;
    logic [31:0] w_cur;
    logic [31:0] s1, ch, t1, s0, mj, t2;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign sum    = hrd + v_reg[0];

    always_comb
    begin
        hctrl.init_all = accept && (word_cnt_reg == 4'd0) && msg.first_block;
        hctrl.rd_addr  = cnt_reg[2:0];
        hctrl.wr_en    = (state_reg == S_ADD) && (cnt_reg != 4'd0);
        hctrl.wr_addr  = cnt_reg[2:0] - 3'd1;
        hctrl.wr_data  = sum;
    end

    sha256_hmem u_hmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hctrl),
        .rd_data (hrd)
    );

    sha256_sched u_sched (
        .clk     (clk),
        .load    (accept),
        .step    (state_reg == S_ROUND),
        .word_in (msg.msg_word),
        .w_cur   (w_cur)
    );

    always_comb
    begin
        s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + round_const(round_reg) + w_cur;
        s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = 4'd0;
                if (accept && (word_cnt_reg == 4'd15))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    state_next = S_ROUND;
                    cnt_next   = 4'd0;
                    round_next = 6'd0;
                end
            end
            S_ROUND:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = S_ADD;
                    cnt_next   = 4'd0;
                end
            end
            S_ADD:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    state_next = S_IDLE;
                    cnt_next   = 4'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            word_cnt_reg <= 4'd0;
            cnt_reg      <= 4'd0;
            round_reg    <= 6'd0;
            last_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            round_reg  <= round_next;
            strobe_reg <= (state_reg == S_ADD) && (cnt_reg != 4'd0) && last_reg;
            if (accept)
            begin
                word_cnt_reg <= word_cnt_reg + 4'd1;
                if (word_cnt_reg == 4'd15)
                begin
                    last_reg <= msg.last_block;
                end
            end
        end
    end

    // working vars: shift in on load, rounds, rotate out on add
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_LOAD) && (cnt_reg != 4'd0))
        begin
            for (int i = 0; i < HashWords - 1; i++)
            begin
                v_reg[i] <= v_reg[i+1];
            end
            v_reg[HashWords-1] <= hrd;
        end
        else if (state_reg == S_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if ((state_reg == S_ADD) && (cnt_reg != 4'd0))
        begin
            for (int i = 0; i < HashWords - 1; i++)
            begin
                v_reg[i] <= v_reg[i+1];
            end
            v_reg[HashWords-1] <= v_reg[0];
        end
        digest_reg.digest_word  <= sum;
        digest_reg.digest_index <= cnt_reg[2:0] - 3'd1;
        digest_reg.digest_last  <= (cnt_reg == 4'd8);
    end

    assign strobe = strobe_reg;
    assign digest = digest_reg;

`ifndef SYNTHESIS
    a_strobe_from_add: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == S_ADD))
        else $error("digest strobe outside add pass");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (digest.digest_last == (digest.digest_index == 3'd7)))
        else $error("digest_last does not match index");

    a_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) && (round_reg == 6'd63) |=> (state_reg == S_ADD))
        else $error("compression did not end after round 63");

    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (word_cnt_reg == 4'd15) |=> (state_reg == S_LOAD) && (word_cnt_reg == 4'd0))
        else $error("sixteenth word did not start compression");

    a_no_write_outside_add: assert property (@(posedge clk) disable iff (!rst_n)
        hctrl.wr_en |-> (state_reg == S_ADD) && !accept)
        else $error("hash memory write outside add pass");
`endif

endmodule

`default_nettype wire

@@ dv/sha256_checker.sv @@
`timescale 1ns / 1ps

module sha256_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire sha256_pkg::in_t   msg,
    input  wire logic              strobe,
    input  wire sha256_pkg::out_t  digest,
    output int                     mismatches,
    output int                     pending
);

    import sha256_pkg::*;

    localparam int LastWordPos = BlockWords - 1;

    localparam logic [31:0] IV_WORDS [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_WORDS [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0] chain_h [HashWords];
    logic [31:0] sched_w [BlockWords];
    logic [3:0]  word_pos;
    out_t        digest_q [$];

    assign pending = digest_q.size();

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over the rolling schedule, then fold into the chaining value
    function automatic void compress_block();
        logic [31:0] v [HashWords];
        logic [31:0] w, w2, w15, s0, s1, ch, mj, t1, t2;
        int slot;
        for (int i = 0; i < HashWords; i++)
            v[i] = chain_h[i];
        for (int r = 0; r < Rounds; r++)
        begin
            slot = r % BlockWords;
            if (r < BlockWords)
                w = sched_w[slot];
            else
            begin
                w2  = sched_w[(r - 2) % BlockWords];
                w15 = sched_w[(r - 15) % BlockWords];
                w = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10))
                    + sched_w[(r - 7) % BlockWords]
                    + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
                    + sched_w[slot];
                sched_w[slot] = w;
            end
            s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + K_WORDS[r] + w;
            s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < HashWords; i++)
            chain_h[i] = chain_h[i] + v[i];
    endfunction

    function automatic void absorb_word(input in_t item);
        out_t exp_word;
        if (word_pos == 4'd0 && item.first_block)
            for (int i = 0; i < HashWords; i++)
                chain_h[i] = IV_WORDS[i];
        sched_w[word_pos] = item.msg_word;
        if (word_pos != LastWordPos)
            word_pos = word_pos + 4'd1;
        else
        begin
            word_pos = 4'd0;
            compress_block();
            if (item.last_block)
                for (int i = 0; i < HashWords; i++)
                begin
                    exp_word.digest_word  = chain_h[i];
                    exp_word.digest_index = i[2:0];
                    exp_word.digest_last  = (i == HashWords - 1);
                    digest_q = {digest_q, exp_word};
                end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HashWords; i++)
                chain_h[i] = IV_WORDS[i];
            for (int i = 0; i < BlockWords; i++)
                sched_w[i] = '0;
            word_pos = 4'd0;
            digest_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (start && !busy)
                absorb_word(msg);
            if (strobe)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t digest transaction with nothing expected: expected none actual %h",
                             $time, digest);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    out_t exp_word;
                    exp_word = digest_q.pop_front();
                    if (digest.digest_word !== exp_word.digest_word)
                    begin
                        $display("%0t digest_word: expected %h actual %h",
                                 $time, exp_word.digest_word, digest.digest_word);
                        mismatches = mismatches + 1;
                    end
                    if (digest.digest_index !== exp_word.digest_index)
                    begin
                        $display("%0t digest_index: expected %0d actual %0d",
                                 $time, exp_word.digest_index, digest.digest_index);
                        mismatches = mismatches + 1;
                    end
                    if (digest.digest_last !== exp_word.digest_last)
                    begin
                        $display("%0t digest_last: expected %b actual %b",
                                 $time, exp_word.digest_last, digest.digest_last);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import sha256_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int TailCycles  = 120;
    localparam int RandomWords = 100;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    logic  busy;
    in_t   msg;
    logic  strobe;
    out_t  digest;
    int    mismatches;
    int    pending;
    int    cycles = 0;

    sha256_block_hash dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .msg    (msg),
        .strobe (strobe),
        .digest (digest)
    );

    sha256_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .msg        (msg),
        .strobe     (strobe),
        .digest     (digest),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // returns once the transaction is taken and the core is not busy
    task automatic send_word(input logic [31:0] word, input logic first, input logic last);
        start <= 1'b1;
        msg   <= '{msg_word: word, first_block: first, last_block: last};
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_digests();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    int burst_left = 0;

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // mostly short gaps, some long enough to span a whole compression
            case ($urandom_range(0, 9))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(40, 130);
                default: gap = $urandom_range(1, 6);
            endcase
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48)
                                                     : $urandom_range(0, 12);
            idle_for(gap);
        end
    endtask

    initial
    begin
        int sent;
        int blocks_left;
        logic new_msg;
        logic [31:0] word;
        logic first, last;

        rst_n = 1'b0;
        start = 1'b0;
        msg   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // padded "abc" right after reset with no first flag; stray flags on every word
        for (int i = 0; i < BlockWords; i++)
        begin
            word = (i == 0) ? 32'h61626380 : (i == BlockWords - 1) ? 32'h00000018 : 32'h0;
            send_word(word, (i != 0) && i[0], (i == BlockWords - 1) || !i[0]);
        end
        drain_digests();

        // chaining after a digest, all-ones and all-zeros words
        for (int i = 0; i < 9; i++)
        begin
            send_word(i[0] ? 32'h00000000 : 32'hffffffff, 1'b0, i[0]);
            if (i == 4)
                idle_for(3);
        end

        // random part: mostly well-formed messages, some flag noise
        sent = 0;
        blocks_left = 0;
        new_msg = 1'b0;
        for (int pos = 9; sent < RandomWords || pos != 0;
             pos = (pos + 1) % BlockWords)
        begin
            if (pos == 0 && blocks_left == 0)
            begin
                blocks_left = $urandom_range(1, 3);
                new_msg = ($urandom_range(0, 9) != 0);
            end
            word = ($urandom_range(0, 15) == 0) ? {32{$urandom_range(0, 1) == 1}} : $urandom;
            if (pos == 0)
                first = new_msg;
            else
                first = ($urandom_range(0, 3) == 0);
            if (pos == BlockWords - 1)
                last = (blocks_left == 1) || ($urandom_range(0, 19) == 0);
            else
                last = ($urandom_range(0, 3) == 0);
            send_word(word, first, last);
            sent++;
            if (pos == 0)
                new_msg = 1'b0;
            if (pos == BlockWords - 1)
            begin
                if (blocks_left > 0)
                    blocks_left--;
                if (last && $urandom_range(0, 3) == 0)
                    drain_digests();
                else
                    pace();
            end
            else
                pace();
        end

        drain_digests();
        repeat (TailCycles) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
